// File: sv/cdeq_pkg.sv
`timescale 1ns / 1ps

package cdeq_pkg;

  typedef enum logic [1:0] {
    FUNC_PUSH_BACK  = 2'd0,
    FUNC_PUSH_FRONT = 2'd1,
    FUNC_POP_FRONT  = 2'd2,
    FUNC_POP_BACK   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD
  } state_e;

  localparam int unsigned ValueW = 32;
  localparam int unsigned CountW = 6;

  typedef struct packed {
    func_e              func;
    logic [ValueW-1:0]  value;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic [CountW-1:0]  count;
    logic [ValueW-1:0]  front_value;
    logic [ValueW-1:0]  back_value;
  } rsp_t;

endpackage

// File: sv/circular_double_ended_queue_core.sv
`timescale 1ns / 1ps

// Fixed-capacity double-ended queue kept in a ring store.
// in channel: in_valid_i / in_ready_o with in_req_i (func, value). func selects
//   push back, push front, pop front or pop back; value is used by pushes only.
// out channel: out_valid_o / out_ready_i with out_rsp_o (status, count,
//   front_value, back_value). Exactly one response per request, in order.
//   front_value and back_value read zero when the queue is empty.
// A full push or an empty pop is rejected with a status code; state is kept.
// The response is registered: an accepted request passes through ST_READ and
//   ST_LOAD, then loads the output register; no new request is taken until the
//   sequencer is back in ST_IDLE. The request cycle updates head, count and the
//   store write; the next cycle reads front and back from the registered read
//   port of the single ring memory, so the write lands before that read.
// A response waiting on a stalled receiver sits in the output register; the next
//   request is still taken and its result waits in the read data until the
//   output register frees up.
// Reset clears head, count, the sequencer and the output valid. The store has no
//   reset; an unwritten entry is read only while the queue is empty, shown as zero.
module circular_double_ended_queue_core #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned WIDTH = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  cdeq_pkg::req_t  in_req_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output cdeq_pkg::rsp_t  out_rsp_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = CW + 1;

  function automatic logic [AW-1:0] wrap_idx(input logic [SW-1:0] s);
    return (s >= SW'(DEPTH)) ? AW'(s - SW'(DEPTH)) : AW'(s);
  endfunction

  cdeq_pkg::state_e  state_q, state_d;
  logic [AW-1:0]     head_q, head_d;
  logic [CW-1:0]     count_q, count_d;
  cdeq_pkg::status_e status_q, status_d;

  logic              out_valid_q, out_valid_d;
  cdeq_pkg::rsp_t    out_rsp_q, out_rsp_d;

  logic              accept;
  logic              full;
  logic              empty;
  logic              load_out;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [WIDTH-1:0]  mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr_a;
  logic [AW-1:0]     mem_raddr_b;
  logic [WIDTH-1:0]  mem_rdata_a;
  logic [WIDTH-1:0]  mem_rdata_b;

  assign in_ready_o = (state_q == cdeq_pkg::ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign full       = (count_q == CW'(DEPTH));
  assign empty      = (count_q == '0);
  assign load_out   = (state_q == cdeq_pkg::ST_LOAD) && (!out_valid_q || out_ready_i);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cdeq_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = cdeq_pkg::ST_READ;
        end
      end
      cdeq_pkg::ST_READ: begin
        state_d = cdeq_pkg::ST_LOAD;
      end
      cdeq_pkg::ST_LOAD: begin
        if (load_out) begin
          state_d = cdeq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = cdeq_pkg::ST_IDLE;
      end
    endcase
  end

  // queue update and store write on request
  always_comb begin
    head_d    = head_q;
    count_d   = count_q;
    status_d  = status_q;
    mem_we    = 1'b0;
    mem_waddr = head_q;
    mem_wdata = WIDTH'(in_req_i.value);
    if (accept) begin
      status_d = cdeq_pkg::STATUS_DONE;
      unique case (in_req_i.func)
        cdeq_pkg::FUNC_PUSH_BACK: begin
          if (full) begin
            status_d = cdeq_pkg::STATUS_FULL;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = wrap_idx(SW'(head_q) + SW'(count_q));
            count_d   = count_q + CW'(1);
          end
        end
        cdeq_pkg::FUNC_PUSH_FRONT: begin
          if (full) begin
            status_d = cdeq_pkg::STATUS_FULL;
          end else begin
            head_d    = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);
            mem_we    = 1'b1;
            mem_waddr = head_d;
            count_d   = count_q + CW'(1);
          end
        end
        cdeq_pkg::FUNC_POP_FRONT: begin
          if (empty) begin
            status_d = cdeq_pkg::STATUS_EMPTY;
          end else begin
            head_d  = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
            count_d = count_q - CW'(1);
          end
        end
        cdeq_pkg::FUNC_POP_BACK: begin
          if (empty) begin
            status_d = cdeq_pkg::STATUS_EMPTY;
          end else begin
            count_d = count_q - CW'(1);
          end
        end
        default: begin
          status_d = cdeq_pkg::STATUS_DONE;
        end
      endcase
    end
  end

  // outputs: store read and response load
  always_comb begin
    mem_re      = (state_q == cdeq_pkg::ST_READ);
    mem_raddr_a = head_q;
    mem_raddr_b = wrap_idx(SW'(head_q) + SW'(count_q - CW'(1)));

    out_rsp_d             = out_rsp_q;
    out_rsp_d.status      = status_q;
    out_rsp_d.count       = cdeq_pkg::CountW'(count_q);
    out_rsp_d.front_value = empty ? '0 : cdeq_pkg::ValueW'(mem_rdata_a);
    out_rsp_d.back_value  = empty ? '0 : cdeq_pkg::ValueW'(mem_rdata_b);

    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cdeq_pkg::ST_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      status_q    <= cdeq_pkg::STATUS_DONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      status_q    <= status_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_rsp_q <= out_rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  cdeq_ram #(
    .DEPTH (DEPTH),
    .WIDTH (WIDTH)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .re_i      (mem_re),
    .raddr_a_i (mem_raddr_a),
    .raddr_b_i (mem_raddr_b),
    .rdata_a_o (mem_rdata_a),
    .rdata_b_o (mem_rdata_b)
  );

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("element count above capacity");

  a_accept_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == cdeq_pkg::ST_READ))
    else $error("request not followed by store read");

  a_write_on_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (accept && !in_req_i.func[1]))
    else $error("store written outside a push request");

  a_reject_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && ((!in_req_i.func[1] && full) || (in_req_i.func[1] && empty)))
    |=> (count_q == $past(count_q)) && (head_q == $past(head_q)))
    else $error("rejected request changed queue state");

  a_no_read_write_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("store read and write in the same cycle");
`endif

endmodule

// File: sv/cdeq_ram.sv
`timescale 1ns / 1ps

module cdeq_ram #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem[raddr_a_i];
      rdata_b_o <= mem[raddr_b_i];
    end
  end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned QDepth     = 32;
  localparam int unsigned DirRows    = 24;
  localparam int unsigned NumRand    = 1326;
  localparam int unsigned QuietTail  = 150;
  localparam int unsigned HoldAt     = 300;
  localparam int unsigned HoldCycles = 150;
  localparam int unsigned DrainWait  = 8;
  localparam int unsigned ExpDepth   = 64;

  typedef struct packed {
    cdeq_pkg::func_e func;
    logic [31:0]     value;
    logic            lit;
    cdeq_pkg::rsp_t  rsp;
  } row_t;

  logic           clk_i;
  logic           rst_ni;
  logic           in_valid_i;
  logic           in_ready_o;
  cdeq_pkg::req_t in_req_i;
  logic           out_valid_o;
  logic           out_ready_i;
  cdeq_pkg::rsp_t out_rsp_o;

  logic           lit_row;
  cdeq_pkg::rsp_t lit_rsp;

  row_t dir_tab [DirRows];

  logic [31:0]    shadow_ring [QDepth];
  int unsigned    shadow_head;
  int unsigned    shadow_fill;

  // expected responses, oldest first
  cdeq_pkg::rsp_t exp_fifo [ExpDepth];
  bit [5:0]       exp_wr;
  bit [5:0]       exp_rd;
  int unsigned    exp_cnt;

  int unsigned err_cnt;
  int unsigned req_cnt;
  int unsigned rsp_cnt;
  int unsigned full_cnt;
  int unsigned empty_cnt;
  int unsigned peak_fill;
  int unsigned plan_fill;
  int unsigned rnd_cnt;
  bit          quiet;
  bit          hold_req;
  bit          hold_active;
  bit          hold_done;

  circular_double_ended_queue_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #5_000_000;
    $display("%0t: timeout, %0d responses still pending", $time, exp_cnt);
    $display("circular_double_ended_queue_core verification failed");
    $finish;
  end

  function automatic cdeq_pkg::rsp_t deque_apply(input cdeq_pkg::req_t r);
    cdeq_pkg::rsp_t o;
    o = '0;
    o.status = cdeq_pkg::STATUS_DONE;
    case (r.func)
      cdeq_pkg::FUNC_PUSH_BACK, cdeq_pkg::FUNC_PUSH_FRONT: begin
        if (shadow_fill >= QDepth) begin
          o.status = cdeq_pkg::STATUS_FULL;
        end else if (r.func == cdeq_pkg::FUNC_PUSH_BACK) begin
          shadow_ring[(shadow_head + shadow_fill) % QDepth] = r.value;
          shadow_fill++;
        end else begin
          shadow_head = (shadow_head + QDepth - 1) % QDepth;
          shadow_ring[shadow_head] = r.value;
          shadow_fill++;
        end
      end
      default: begin
        if (shadow_fill == 0) begin
          o.status = cdeq_pkg::STATUS_EMPTY;
        end else begin
          if (r.func == cdeq_pkg::FUNC_POP_FRONT) shadow_head = (shadow_head + 1) % QDepth;
          shadow_fill--;
        end
      end
    endcase
    o.count = shadow_fill[5:0];
    if (shadow_fill != 0) begin
      o.front_value = shadow_ring[shadow_head];
      o.back_value  = shadow_ring[(shadow_head + shadow_fill - 1) % QDepth];
    end
    return o;
  endfunction

  function automatic row_t mk_row(input cdeq_pkg::func_e f, input logic [31:0] v,
                                  input logic lit, input cdeq_pkg::status_e s,
                                  input logic [5:0] c,
                                  input logic [31:0] fv, input logic [31:0] bv);
    row_t r;
    r.func            = f;
    r.value           = v;
    r.lit             = lit;
    r.rsp.status      = s;
    r.rsp.count       = c;
    r.rsp.front_value = fv;
    r.rsp.back_value  = bv;
    return r;
  endfunction

  function automatic logic [31:0] rand_value();
    int unsigned sel;
    sel = $urandom_range(0, 7);
    if (sel == 0) return 32'h0000_0000;
    if (sel == 1) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  always @(posedge clk_i) begin
    cdeq_pkg::rsp_t pred;
    cdeq_pkg::rsp_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        rsp_cnt++;
        if (exp_cnt == 0) begin
          $display("%0t: response with no request pending, got %h", $time, out_rsp_o);
          err_cnt++;
        end else begin
          want = exp_fifo[exp_rd];
          exp_rd = exp_rd + 6'd1;
          exp_cnt--;
          if (out_rsp_o.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, want.status, out_rsp_o.status);
            err_cnt++;
          end
          if (out_rsp_o.count !== want.count) begin
            $display("%0t: count mismatch, expected %0d, got %0d",
                     $time, want.count, out_rsp_o.count);
            err_cnt++;
          end
          if (out_rsp_o.front_value !== want.front_value) begin
            $display("%0t: front_value mismatch, expected %h, got %h",
                     $time, want.front_value, out_rsp_o.front_value);
            err_cnt++;
          end
          if (out_rsp_o.back_value !== want.back_value) begin
            $display("%0t: back_value mismatch, expected %h, got %h",
                     $time, want.back_value, out_rsp_o.back_value);
            err_cnt++;
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        pred = deque_apply(in_req_i);
        req_cnt++;
        if (pred.status == cdeq_pkg::STATUS_FULL) full_cnt++;
        if (pred.status == cdeq_pkg::STATUS_EMPTY) empty_cnt++;
        if (shadow_fill > peak_fill) peak_fill = shadow_fill;
        if (exp_cnt >= ExpDepth) begin
          $display("%0t: more than %0d responses outstanding", $time, ExpDepth);
          err_cnt++;
        end else begin
          exp_fifo[exp_wr] = lit_row ? lit_rsp : pred;
          exp_wr = exp_wr + 6'd1;
          exp_cnt++;
        end
      end
    end
  end

  initial begin
    int unsigned n;
    out_ready_i <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (quiet) begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end else if (hold_req && !hold_done) begin
        // long hold-off so the queue backs up into the request side
        hold_active = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_active = 1'b0;
        hold_done   = 1'b1;
      end else begin
        n = $urandom_range(1, 18);
        out_ready_i <= ($urandom_range(0, 2) != 0);
        repeat (n) @(posedge clk_i);
      end
    end
  end

  task automatic offer(input cdeq_pkg::func_e f, input logic [31:0] v, input logic lit,
                       input cdeq_pkg::rsp_t lrsp);
    cdeq_pkg::req_t r;
    r.func  = f;
    r.value = v;
    if (!quiet && !hold_active && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    in_req_i   <= r;
    lit_row    <= lit;
    lit_rsp    <= lrsp;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    if (f == cdeq_pkg::FUNC_PUSH_BACK || f == cdeq_pkg::FUNC_PUSH_FRONT) begin
      if (plan_fill < QDepth) plan_fill++;
    end else if (plan_fill > 0) begin
      plan_fill--;
    end
  endtask

  initial begin
    int unsigned     pick;
    int unsigned     seg_len;
    cdeq_pkg::func_e f;
    in_valid_i <= 1'b0;
    in_req_i   <= '0;
    lit_row    <= 1'b0;
    lit_rsp    <= '0;

    dir_tab[0]  = mk_row(cdeq_pkg::FUNC_POP_FRONT,  32'h0000_0000, 1,
                         cdeq_pkg::STATUS_EMPTY, 0, 0, 0);
    dir_tab[1]  = mk_row(cdeq_pkg::FUNC_POP_BACK,   32'hFFFF_FFFF, 1,
                         cdeq_pkg::STATUS_EMPTY, 0, 0, 0);
    dir_tab[2]  = mk_row(cdeq_pkg::FUNC_PUSH_BACK,  32'h0000_0000, 1,
                         cdeq_pkg::STATUS_DONE, 1, 0, 0);
    dir_tab[3]  = mk_row(cdeq_pkg::FUNC_PUSH_BACK,  32'hFFFF_FFFF, 1,
                         cdeq_pkg::STATUS_DONE, 2, 0, 32'hFFFF_FFFF);
    dir_tab[4]  = mk_row(cdeq_pkg::FUNC_PUSH_FRONT, 32'h8000_0000, 1,
                         cdeq_pkg::STATUS_DONE, 3, 32'h8000_0000, 32'hFFFF_FFFF);
    dir_tab[5]  = mk_row(cdeq_pkg::FUNC_PUSH_FRONT, 32'h0000_0001, 1,
                         cdeq_pkg::STATUS_DONE, 4, 32'h0000_0001, 32'hFFFF_FFFF);
    dir_tab[6]  = mk_row(cdeq_pkg::FUNC_POP_BACK,   32'hFFFF_FFFF, 1,
                         cdeq_pkg::STATUS_DONE, 3, 32'h0000_0001, 0);
    dir_tab[7]  = mk_row(cdeq_pkg::FUNC_POP_FRONT,  32'h0000_0000, 1,
                         cdeq_pkg::STATUS_DONE, 2, 32'h8000_0000, 0);
    dir_tab[8]  = mk_row(cdeq_pkg::FUNC_POP_FRONT,  32'hFFFF_FFFF, 1,
                         cdeq_pkg::STATUS_DONE, 1, 0, 0);
    dir_tab[9]  = mk_row(cdeq_pkg::FUNC_POP_BACK,   32'h0000_0000, 1,
                         cdeq_pkg::STATUS_DONE, 0, 0, 0);
    dir_tab[10] = mk_row(cdeq_pkg::FUNC_POP_BACK,   32'hFFFF_FFFF, 1,
                         cdeq_pkg::STATUS_EMPTY, 0, 0, 0);
    dir_tab[11] = mk_row(cdeq_pkg::FUNC_PUSH_FRONT, 32'hA5A5_A5A5, 1,
                         cdeq_pkg::STATUS_DONE, 1, 32'hA5A5_A5A5, 32'hA5A5_A5A5);
    dir_tab[12] = mk_row(cdeq_pkg::FUNC_PUSH_BACK,  32'h5A5A_5A5A, 1,
                         cdeq_pkg::STATUS_DONE, 2, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
    dir_tab[13] = mk_row(cdeq_pkg::FUNC_POP_FRONT,  32'h0000_0000, 1,
                         cdeq_pkg::STATUS_DONE, 1, 32'h5A5A_5A5A, 32'h5A5A_5A5A);
    dir_tab[14] = mk_row(cdeq_pkg::FUNC_PUSH_BACK,  32'h1234_5678, 0,
                         cdeq_pkg::STATUS_DONE, 0, 0, 0);
    dir_tab[15] = mk_row(cdeq_pkg::FUNC_PUSH_FRONT, 32'hFFFF_0000, 0,
                         cdeq_pkg::STATUS_DONE, 0, 0, 0);
    dir_tab[16] = mk_row(cdeq_pkg::FUNC_POP_BACK,   32'h0000_0000, 0,
                         cdeq_pkg::STATUS_DONE, 0, 0, 0);
    dir_tab[17] = mk_row(cdeq_pkg::FUNC_PUSH_BACK,  32'h0000_FFFF, 0,
                         cdeq_pkg::STATUS_DONE, 0, 0, 0);
    dir_tab[18] = mk_row(cdeq_pkg::FUNC_POP_FRONT,  32'hFFFF_FFFF, 0,
                         cdeq_pkg::STATUS_DONE, 0, 0, 0);
    dir_tab[19] = mk_row(cdeq_pkg::FUNC_PUSH_FRONT, 32'h7FFF_FFFF, 0,
                         cdeq_pkg::STATUS_DONE, 0, 0, 0);
    dir_tab[20] = mk_row(cdeq_pkg::FUNC_PUSH_FRONT, 32'hFFFF_FFFE, 0,
                         cdeq_pkg::STATUS_DONE, 0, 0, 0);
    dir_tab[21] = mk_row(cdeq_pkg::FUNC_POP_BACK,   32'h0000_0000, 0,
                         cdeq_pkg::STATUS_DONE, 0, 0, 0);
    dir_tab[22] = mk_row(cdeq_pkg::FUNC_POP_FRONT,  32'h0000_0000, 0,
                         cdeq_pkg::STATUS_DONE, 0, 0, 0);
    dir_tab[23] = mk_row(cdeq_pkg::FUNC_POP_FRONT,  32'hFFFF_FFFF, 0,
                         cdeq_pkg::STATUS_DONE, 0, 0, 0);

    wait (rst_ni);
    @(posedge clk_i);
    for (int i = 0; i < DirRows; i++) begin
      offer(dir_tab[i].func, dir_tab[i].value, dir_tab[i].lit, dir_tab[i].rsp);
    end

    // random part: fill runs, drain runs and mixed traffic
    while (rnd_cnt < NumRand) begin
      pick = $urandom_range(0, 9);
      if (pick < 3) seg_len = QDepth - plan_fill + $urandom_range(1, 4);
      else if (pick < 6) seg_len = plan_fill + $urandom_range(1, 4);
      else seg_len = $urandom_range(8, 40);
      for (int k = 0; k < seg_len && rnd_cnt < NumRand; k++) begin
        if (pick < 3) begin
          f = ($urandom_range(0, 1) != 0) ? cdeq_pkg::FUNC_PUSH_BACK
                                          : cdeq_pkg::FUNC_PUSH_FRONT;
        end else if (pick < 6) begin
          f = ($urandom_range(0, 1) != 0) ? cdeq_pkg::FUNC_POP_FRONT
                                          : cdeq_pkg::FUNC_POP_BACK;
        end else begin
          f = cdeq_pkg::func_e'($urandom_range(0, 3));
        end
        offer(f, rand_value(), 1'b0, '0);
        rnd_cnt++;
        if (rnd_cnt == HoldAt) hold_req = 1'b1;
        if (rnd_cnt == NumRand - QuietTail) quiet = 1'b1;
      end
    end
    in_valid_i <= 1'b0;

    @(posedge clk_i);
    while (exp_cnt != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    $display("Ran %0d requests (%0d from the table), checked %0d responses.",
             req_cnt, DirRows, rsp_cnt);
    $display("Saw %0d full rejects, %0d empty rejects, peak occupancy %0d of %0d.",
             full_cnt, empty_cnt, peak_fill, QDepth);
    if (err_cnt == 0) begin
      $display("circular_double_ended_queue_core verification clean");
    end else begin
      $display("circular_double_ended_queue_core verification failed");
    end
    $finish;
  end

endmodule
